/* sv/assert_macros.svh */
// Assertion macros for the checker file.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* sv/gbn_pkg.sv */
// Shared constants, codes and types for the go-back-n sender.
// No dependencies; used by the interfaces, the top level and the checker.
package gbn_pkg;

  localparam int WINDOW_DEPTH  = 8;
  localparam int SLOT_BITS     = $clog2(WINDOW_DEPTH);
  localparam int CNT_BITS      = $clog2(WINDOW_DEPTH + 1);
  localparam int SEQ_BITS      = 16;
  localparam int PAYLOAD_BITS  = 32;
  localparam int TIMER_BITS    = 24;
  localparam int WSIZE_BITS    = 3;
  localparam int TOTAL_BITS    = 16;
  localparam int OP_BITS       = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;

  localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = WSIZE_BITS'(3);
  localparam logic [TOTAL_BITS-1:0] TOTAL_RESET = TOTAL_BITS'(1);
  localparam logic [TIMER_BITS-1:0] LIMIT_RESET = TIMER_BITS'(10000000);
  localparam logic [TIMER_BITS-1:0] TIMER_MAX   = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_SIZE   = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_TOTAL_FRAMES  = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT_LIMIT = CFG_IDX_BITS'(2);

  typedef enum logic [OP_BITS-1:0] {
    OP_OFFER = 2'd0,
    OP_ACK   = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_DECIDE,
    S_FLUSH_RD,
    S_FLUSH_EMIT
  } state_t;

  typedef struct packed {
    logic                    frame_valid;
    logic [SEQ_BITS-1:0]     frame_seq;
    logic [PAYLOAD_BITS-1:0] frame_data;
    logic                    is_resend;
    logic                    is_end_marker;
    logic                    offer_taken;
    logic [SEQ_BITS-1:0]     window_base;
    logic [SEQ_BITS-1:0]     next_to_send;
    logic                    last;
  } res_t;

endpackage

/* sv/gbn_ifs.sv */
// Valid/ready channel interfaces for the command and result sides.
// Depends on gbn_pkg for field widths.
interface gbn_cmd_if;
  import gbn_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OP_BITS-1:0]      operation;
  logic [PAYLOAD_BITS-1:0] payload;
  logic [SEQ_BITS-1:0]     ack_seq;

  modport source (output valid, operation, payload, ack_seq, input ready);
  modport sink   (input valid, operation, payload, ack_seq, output ready);
endinterface

interface gbn_rsp_if;
  import gbn_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    frame_valid;
  logic [SEQ_BITS-1:0]     frame_seq;
  logic [PAYLOAD_BITS-1:0] frame_data;
  logic                    is_resend;
  logic                    is_end_marker;
  logic                    offer_taken;
  logic [SEQ_BITS-1:0]     window_base;
  logic [SEQ_BITS-1:0]     next_to_send;
  logic                    last;

  modport source (output valid, frame_valid, frame_seq, frame_data, is_resend, is_end_marker,
                  offer_taken, window_base, next_to_send, last, input ready);
  modport sink   (input valid, frame_valid, frame_seq, frame_data, is_resend, is_end_marker,
                  offer_taken, window_base, next_to_send, last, output ready);
endinterface

/* sv/gbn_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module gbn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/go_back_n_sender.sv */
// Go-back-n sender window. Offers, acks and idle ticks: one result in the cycle after the beat.
// A tick over n active slots (frames in flight capped at the window size, n <= 7) sweeps the
// timer RAM, then S_DECIDE loads its status result once the output is free, or starts a resend.
// On timeout each resend runs S_FLUSH_RD (store read) and S_FLUSH_EMIT (output load, held while
// the output is busy), timers beyond the active window are cleared, and the next command waits.
// Synchronous reset loads register defaults and empties the window; timers rearm on offer.
module go_back_n_sender (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gbn_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [gbn_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  gbn_cmd_if.sink                             cmd,
  gbn_rsp_if.source                           rsp
);
  import gbn_pkg::*;

  // configuration
  logic [WSIZE_BITS-1:0] cfg_wsize;
  logic [TOTAL_BITS-1:0] cfg_total;
  logic [TIMER_BITS-1:0] cfg_limit;

  // control state
  state_t              state, state_next;
  logic [SEQ_BITS-1:0] oldest, oldest_next;
  logic [SEQ_BITS-1:0] nseq, nseq_next;
  logic [CNT_BITS-1:0] idx, idx_next;
  logic [CNT_BITS-1:0] n_q, n_next;
  logic [CNT_BITS-1:0] outs_q, outs_next;
  logic                fire, fire_next;
  logic                pvalid, pvalid_next;
  logic [SLOT_BITS-1:0] paddr, paddr_next;

  // output register
  logic out_valid;
  res_t res, res_d;
  logic res_load;
  logic out_free;

  // RAM ports
  logic                    tm_we, tm_re;
  logic [SLOT_BITS-1:0]    tm_waddr, tm_raddr;
  logic [TIMER_BITS-1:0]   tm_wdata, tm_rdata, timer_inc;
  logic                    st_we, st_re;
  logic [SLOT_BITS-1:0]    st_raddr;
  logic [PAYLOAD_BITS-1:0] st_rdata;

  // derived values
  logic [CNT_BITS-1:0]  win;
  logic [SEQ_BITS-1:0]  outs;
  logic [SEQ_BITS-1:0]  ack_plus;
  logic [SEQ_BITS-1:0]  nseq_plus;
  logic [CNT_BITS-1:0]  tick_n;
  logic [CNT_BITS-1:0]  idx_inc;
  logic [SLOT_BITS-1:0] slot_cur, slot_new;
  logic                 offer_ok, ack_ok, idx_last, cmd_accept;

  function automatic res_t status_res(logic [SEQ_BITS-1:0] base, logic [SEQ_BITS-1:0] nxt);
    res_t r;
    r              = '0;
    r.window_base  = base;
    r.next_to_send = nxt;
    r.last         = 1'b1;
    return r;
  endfunction

  gbn_ram #(.WIDTH(TIMER_BITS), .DEPTH(WINDOW_DEPTH)) u_timer_ram (
    .clk   (clk),
    .we    (tm_we),
    .waddr (tm_waddr),
    .wdata (tm_wdata),
    .re    (tm_re),
    .raddr (tm_raddr),
    .rdata (tm_rdata)
  );

  gbn_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(WINDOW_DEPTH)) u_store_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (slot_new),
    .wdata (cmd.payload),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // effective window is capped by the slot count
  always_comb begin
    if (32'(cfg_wsize) < WINDOW_DEPTH) begin
      win = CNT_BITS'(cfg_wsize);
    end else begin
      win = CNT_BITS'(WINDOW_DEPTH);
    end
  end

  assign outs      = nseq - oldest;
  assign ack_plus  = cmd.ack_seq + 1'b1;
  assign nseq_plus = nseq + 1'b1;
  assign tick_n    = (outs < SEQ_BITS'(win)) ? CNT_BITS'(outs) : win;
  assign idx_inc   = idx + 1'b1;
  assign idx_last  = (idx_inc == outs_q);
  assign slot_cur  = SLOT_BITS'(oldest) + SLOT_BITS'(idx);
  assign slot_new  = SLOT_BITS'(nseq);
  assign offer_ok  = (outs < SEQ_BITS'(win)) && (nseq < cfg_total);
  assign ack_ok    = (cmd.ack_seq >= oldest) && (cmd.ack_seq < nseq);
  assign timer_inc = (tm_rdata == TIMER_MAX) ? tm_rdata : tm_rdata + 1'b1;

  assign out_free   = !out_valid || rsp.ready;
  assign cmd.ready  = (state == S_IDLE) && out_free;
  assign cmd_accept = cmd.valid && cmd.ready;

  // next state, RAM control and result assembly
  always_comb begin
    state_next  = state;
    oldest_next = oldest;
    nseq_next   = nseq;
    idx_next    = idx;
    n_next      = n_q;
    outs_next   = outs_q;
    fire_next   = fire;
    pvalid_next = 1'b0;
    paddr_next  = paddr;
    res_load    = 1'b0;
    res_d       = status_res(oldest, nseq);
    tm_we       = 1'b0;
    tm_waddr    = slot_cur;
    tm_wdata    = '0;
    tm_re       = 1'b0;
    tm_raddr    = slot_cur;
    st_we       = 1'b0;
    st_re       = 1'b0;
    st_raddr    = slot_cur;

    // timer write-back, in the cycle after its read
    if (pvalid) begin
      tm_we    = 1'b1;
      tm_waddr = paddr;
      tm_wdata = timer_inc;
      if (timer_inc > cfg_limit) begin
        fire_next = 1'b1;
      end
    end

    unique case (state)
      S_IDLE: begin
        if (cmd_accept) begin
          case (cmd.operation)
            OP_OFFER: begin
              res_load = 1'b1;
              if (offer_ok) begin
                st_we             = 1'b1;
                tm_we             = 1'b1;
                tm_waddr          = slot_new;
                tm_wdata          = '0;
                nseq_next         = nseq_plus;
                res_d             = status_res(oldest, nseq_plus);
                res_d.frame_valid = 1'b1;
                res_d.frame_seq   = nseq;
                res_d.frame_data  = cmd.payload;
                res_d.offer_taken = 1'b1;
              end
            end
            OP_ACK: begin
              res_load = 1'b1;
              // cumulative slide; freed timers are rearmed when the slot is reused
              if (ack_ok) begin
                oldest_next = ack_plus;
                res_d       = status_res(ack_plus, nseq);
                if (ack_plus >= cfg_total) begin
                  res_d.frame_valid   = 1'b1;
                  res_d.frame_seq     = '1;
                  res_d.is_end_marker = 1'b1;
                end
              end
            end
            OP_TICK: begin
              if (tick_n == '0) begin
                res_load = 1'b1;
              end else begin
                n_next     = tick_n;
                outs_next  = CNT_BITS'(outs);
                idx_next   = '0;
                fire_next  = 1'b0;
                state_next = S_TICK;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end

      // issue one timer read per cycle across the active window
      S_TICK: begin
        if (idx != n_q) begin
          tm_re       = 1'b1;
          pvalid_next = 1'b1;
          paddr_next  = slot_cur;
          idx_next    = idx_inc;
        end else if (!pvalid) begin
          state_next = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (fire) begin
          idx_next   = '0;
          state_next = S_FLUSH_RD;
        end else if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      // clear every outstanding timer; fetch frames of the active window
      S_FLUSH_RD: begin
        tm_we    = 1'b1;
        tm_wdata = '0;
        if (idx < n_q) begin
          st_re      = 1'b1;
          state_next = S_FLUSH_EMIT;
        end else if (idx_last) begin
          state_next = S_IDLE;
        end else begin
          idx_next = idx_inc;
        end
      end

      S_FLUSH_EMIT: begin
        if (out_free) begin
          res_load          = 1'b1;
          res_d             = status_res(oldest, nseq);
          res_d.frame_valid = 1'b1;
          res_d.frame_seq   = oldest + SEQ_BITS'(idx);
          res_d.frame_data  = st_rdata;
          res_d.is_resend   = 1'b1;
          res_d.last        = (idx_inc == n_q);
          if (idx_last) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx_inc;
            state_next = S_FLUSH_RD;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      oldest    <= '0;
      nseq      <= '0;
      fire      <= 1'b0;
      pvalid    <= 1'b0;
      out_valid <= 1'b0;
      cfg_wsize <= WSIZE_RESET;
      cfg_total <= TOTAL_RESET;
      cfg_limit <= LIMIT_RESET;
    end else begin
      state  <= state_next;
      oldest <= oldest_next;
      nseq   <= nseq_next;
      fire   <= fire_next;
      pvalid <= pvalid_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW_SIZE:   cfg_wsize <= cfg_data[WSIZE_BITS-1:0];
          REG_TOTAL_FRAMES:  cfg_total <= cfg_data[TOTAL_BITS-1:0];
          REG_TIMEOUT_LIMIT: cfg_limit <= cfg_data[TIMER_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // sweep counters and output payload
  always_ff @(posedge clk) begin
    idx    <= idx_next;
    n_q    <= n_next;
    outs_q <= outs_next;
    paddr  <= paddr_next;
    if (res_load) begin
      res <= res_d;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.frame_valid   = res.frame_valid;
  assign rsp.frame_seq     = res.frame_seq;
  assign rsp.frame_data    = res.frame_data;
  assign rsp.is_resend     = res.is_resend;
  assign rsp.is_end_marker = res.is_end_marker;
  assign rsp.offer_taken   = res.offer_taken;
  assign rsp.window_base   = res.window_base;
  assign rsp.next_to_send  = res.next_to_send;
  assign rsp.last          = res.last;

endmodule

/* sv/gbn_checker.sv */
// Port-level checker for the go-back-n sender, bound to the top level.
// Depends on gbn_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gbn_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              cmd_ready,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic [gbn_pkg::SEQ_BITS-1:0]      frame_seq,
  input logic [gbn_pkg::PAYLOAD_BITS-1:0]  frame_data,
  input logic                              is_resend,
  input logic [gbn_pkg::SEQ_BITS-1:0]      window_base,
  input logic [gbn_pkg::SEQ_BITS-1:0]      next_to_send,
  input logic                              last
);
  import gbn_pkg::*;

  logic [SEQ_BITS-1:0] span;
  logic [SEQ_BITS-1:0] resend_off;

  assign span       = next_to_send - window_base;
  assign resend_off = frame_seq - window_base;

  // a stalled result beat holds
  `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(frame_seq) && $stable(frame_data) && $stable(last))

  // frames in flight never exceed the slot count
  `ASSERT_IMPL(a_window_span, rsp_valid, span <= SEQ_BITS'(WINDOW_DEPTH))

  // a resent frame lies inside the outstanding window
  `ASSERT_IMPL(a_resend_in_window, rsp_valid && is_resend, resend_off < span)

  // no new command is taken in the middle of a resend run
  `ASSERT_IMPL(a_resend_blocks_cmd, rsp_valid && is_resend && !last, !cmd_ready)

endmodule

bind go_back_n_sender gbn_checker u_gbn_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_ready    (cmd.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .frame_seq    (rsp.frame_seq),
  .frame_data   (rsp.frame_data),
  .is_resend    (rsp.is_resend),
  .window_base  (rsp.window_base),
  .next_to_send (rsp.next_to_send),
  .last         (rsp.last)
);
